>>> src/kth_pkg.sv
package kth_pkg;

   // Heap capacity and field widths.
   localparam int MAX_K   = 64;
   localparam int DATA_W  = 32;
   localparam int KCFG_W  = 7;
   localparam int IDX_W   = $clog2(MAX_K);
   localparam int CNT_W   = $clog2(MAX_K + 1);
   localparam int CHILD_W = CNT_W + 1;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [CHILD_W-1:0]       child_type;
   typedef logic [KCFG_W-1:0]        kcfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept_fill;    // store the sample at the fill position
      logic heap_init;      // load the heapify index with k/2 - 1
      logic start_replace;  // sample replaces the root, sift from the root
      logic rd_node;        // read the node at the heapify index
      logic ld_node;        // latch that node as the value being sifted
      logic rd_left;        // read the left child
      logic rd_right;       // latch the left child, read the right child
      logic move_child;     // move the smaller child up into the hole
      logic place;          // write the sifted value into the hole
      logic next_idx;       // step the heapify index down
      logic load_rsp;       // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic filling;        // fewer than k values held
      logic fill_last;      // this fill completes the set
      logic k_multi;        // k is at least two
      logic greater;        // sample is greater than the heap minimum
      logic has_left;       // hole has a left child
      logic child_wins;     // a child is smaller than the sifted value
      logic idx_zero;       // heapify index is at the root
      logic rsp_free;       // result register can take a new result
   } status_type;

endpackage

>>> src/kth_req_if.sv
interface kth_req_if import kth_pkg::*; ();
   logic     valid;
   logic     ready;
   data_type sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

>>> src/kth_rsp_if.sv
interface kth_rsp_if import kth_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     ready_res;
   data_type kth_value;

   modport source (output valid, output ready_res, output kth_value, input ready);
   modport sink (input valid, input ready_res, input kth_value, output ready);
endinterface

>>> src/kth_ram.sv
module kth_ram #(
   parameter int  WIDTH  = 32,
   parameter int  DEPTH  = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/kth_ctrl.sv
module kth_ctrl import kth_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD_NODE,
      S_LD_NODE,
      S_SIFT,
      S_RD_R,
      S_CMP,
      S_NEXT,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      heapify_ff, heapify_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      heapify_in = heapify_ff;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (status.filling) begin
                  cmd.accept_fill = 1'b1;
                  if (status.fill_last && status.k_multi) begin
                     cmd.heap_init = 1'b1;
                     heapify_in    = 1'b1;
                     state_in      = S_RD_NODE;
                  end else begin
                     state_in = S_DONE;
                  end
               end else if (status.greater) begin
                  cmd.start_replace = 1'b1;
                  heapify_in        = 1'b0;
                  state_in          = S_SIFT;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_RD_NODE: begin
            cmd.rd_node = 1'b1;
            state_in    = S_LD_NODE;
         end
         S_LD_NODE: begin
            cmd.ld_node = 1'b1;
            state_in    = S_SIFT;
         end
         S_SIFT: begin
            if (status.has_left) begin
               cmd.rd_left = 1'b1;
               state_in    = S_RD_R;
            end else begin
               cmd.place = 1'b1;
               state_in  = S_NEXT;
            end
         end
         S_RD_R: begin
            cmd.rd_right = 1'b1;
            state_in     = S_CMP;
         end
         S_CMP: begin
            if (status.child_wins) begin
               cmd.move_child = 1'b1;
               state_in       = S_SIFT;
            end else begin
               cmd.place = 1'b1;
               state_in  = S_NEXT;
            end
         end
         S_NEXT: begin
            if (heapify_ff && !status.idx_zero) begin
               cmd.next_idx = 1'b1;
               state_in     = S_RD_NODE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         heapify_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         heapify_ff <= heapify_in;
      end
   end

endmodule

>>> src/kth_dp.sv
module kth_dp import kth_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wen,
   input  kcfg_type   csr_wdata,
   input  data_type   req_sample,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output logic       rsp_ready_res,
   output data_type   rsp_kth_value,
   input  cmd_type    cmd,
   output status_type status
);

   kcfg_type  k_ff, k_in;
   cnt_type   seen_ff, seen_in;
   idx_type   heap_idx_ff, heap_idx_in;
   idx_type   pos_ff, pos_in;
   data_type  cur_val_ff, cur_val_in;
   data_type  lval_ff, lval_in;
   data_type  root_ff, root_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      res_ready_ff, res_ready_in;
   data_type  kth_ff, kth_in;

   cnt_type   k_eff;
   cnt_type   half_k;
   child_type lpos;
   child_type rpos;
   logic      has_right;
   data_type  rval;
   logic      l_less;
   logic      r_less;
   idx_type   best_idx;
   data_type  best_val;
   logic      held_ready;

   logic                wr_en;
   idx_type             wr_addr;
   data_type            wr_data;
   logic                rd_en;
   idx_type             rd_addr;
   logic [DATA_W-1:0]   rd_data;

   // Effective rank: zero acts as one, values above capacity act as capacity.
   always_comb begin
      if (k_ff == '0) begin
         k_eff = cnt_type'(1);
      end else if (int'(k_ff) > MAX_K) begin
         k_eff = cnt_type'(MAX_K);
      end else begin
         k_eff = cnt_type'(k_ff);
      end
   end

   assign half_k     = cnt_type'(k_eff >> 1);
   assign held_ready = (seen_ff >= k_eff);

   // Children of the hole and the compare of the three candidates.
   assign lpos      = (child_type'(pos_ff) << 1) + child_type'(1);
   assign rpos      = lpos + child_type'(1);
   assign has_right = (rpos < child_type'(k_eff));
   assign rval      = $signed(rd_data);
   assign l_less    = (lval_ff < cur_val_ff);
   assign r_less    = has_right && (rval < (l_less ? lval_ff : cur_val_ff));
   assign best_idx  = r_less ? idx_type'(rpos) : idx_type'(lpos);
   assign best_val  = r_less ? rval : lval_ff;

   // Status back to the controller.
   always_comb begin
      status            = '0;
      status.filling    = (seen_ff < k_eff);
      status.fill_last  = (seen_ff == (k_eff - cnt_type'(1)));
      status.k_multi    = (k_eff > cnt_type'(1));
      status.greater    = (req_sample > root_ff);
      status.has_left   = (lpos < child_type'(k_eff));
      status.child_wins = l_less || r_less;
      status.idx_zero   = (heap_idx_ff == '0);
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // Heap memory ports. A moved child is written into the hole above it, and its old slot becomes the hole.
   assign wr_en   = cmd.accept_fill || cmd.move_child || cmd.place;
   assign wr_addr = cmd.accept_fill ? idx_type'(seen_ff) : pos_ff;
   assign wr_data = cmd.accept_fill ? req_sample :
                    (cmd.move_child ? best_val : cur_val_ff);
   assign rd_en   = cmd.rd_node || cmd.rd_left || cmd.rd_right;
   assign rd_addr = cmd.rd_node ? heap_idx_ff :
                    (cmd.rd_left ? idx_type'(lpos) : idx_type'(rpos));

   kth_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_K)
   ) u_heap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Next values of the datapath registers.
   always_comb begin
      k_in         = k_ff;
      seen_in      = seen_ff;
      heap_idx_in  = heap_idx_ff;
      pos_in       = pos_ff;
      cur_val_in   = cur_val_ff;
      lval_in      = lval_ff;
      root_in      = root_ff;
      rsp_valid_in = rsp_valid_ff;
      res_ready_in = res_ready_ff;
      kth_in       = kth_ff;

      if (csr_wen) begin
         k_in    = csr_wdata;
         seen_in = '0;
      end
      if (cmd.accept_fill) begin
         seen_in = seen_ff + cnt_type'(1);
      end
      if (cmd.heap_init) begin
         heap_idx_in = idx_type'(half_k - cnt_type'(1));
      end
      if (cmd.next_idx) begin
         heap_idx_in = heap_idx_ff - idx_type'(1);
      end
      if (cmd.start_replace) begin
         cur_val_in = req_sample;
         pos_in     = '0;
      end
      if (cmd.rd_node) begin
         pos_in = heap_idx_ff;
      end
      if (cmd.ld_node) begin
         cur_val_in = $signed(rd_data);
      end
      if (cmd.rd_right) begin
         lval_in = $signed(rd_data);
      end
      if (cmd.move_child) begin
         pos_in = best_idx;
      end

      // The root copy follows every write to the top of the heap.
      if (wr_en && (wr_addr == '0)) begin
         root_in = wr_data;
      end

      // Result register.
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         res_ready_in = held_ready;
         kth_in       = held_ready ? root_ff : '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= kcfg_type'(1);
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      heap_idx_ff  <= heap_idx_in;
      pos_ff       <= pos_in;
      cur_val_ff   <= cur_val_in;
      lval_ff      <= lval_in;
      root_ff      <= root_in;
      res_ready_ff <= res_ready_in;
      kth_ff       <= kth_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ready_res = res_ready_ff;
   assign rsp_kth_value = kth_ff;

`ifndef SYNTHESIS
   // The fill count never passes the rank in force.
   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= k_eff)
      else $error("fill count exceeds rank");

   // Every heap write lands inside the active part of the heap.
   a_wr_in_heap: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (cnt_type'(wr_addr) < k_eff))
      else $error("heap write outside active entries");

   // A result that is not ready carries a zero value.
   a_not_ready_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !res_ready_ff) |-> (kth_ff == '0))
      else $error("nonzero value in a not-ready result");

   // A pending result is only replaced after it has been taken.
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");
`endif

endmodule

>>> src/kth_largest_stream_tracker.sv
// Channel   Direction  Handshake       Payload
// req_bus   in         valid / ready   sample (signed 32)
// rsp_bus   out        valid / ready   ready_res (1), kth_value (signed 32)
// csr       in         csr_wen         csr_wdata = k_count (7)
//
// One transaction in gives one transaction out. A value that only fills the heap
// is stored at the fill position. A value that replaces the minimum is sifted down
// from the root; the single read port of the heap memory splits each level into
// steps (left read, right read, compare and move).
// The value that completes the set also heapifies the stored values, sifting
// each parent node down in turn, from index k/2 - 1 to the root.
// Reset is synchronous and active high; it sets k to 1 and empties the heap.
// A finished result waits in an output register while the next input is taken.
module kth_largest_stream_tracker import kth_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   kth_req_if.sink       req_bus,
   kth_rsp_if.source     rsp_bus,
   input  logic          csr_wen,
   input  kcfg_type      csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // Sequencer for fill, heapify and sift-down.
   kth_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Heap memory, rank, fill count and result register.
   kth_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .req_sample    (req_bus.sample),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready_res (rsp_bus.ready_res),
      .rsp_kth_value (rsp_bus.kth_value),
      .cmd           (cmd),
      .status        (status)
   );

endmodule

>>> tb/kth_largest_stream_tracker_tb.sv
module kth_largest_stream_tracker_tb;
   import kth_pkg::*;

   // Pacing of the two channels during a stimulus phase.
   typedef enum logic [1:0] {
      PACE_FULL,
      PACE_SEND_GAPS,
      PACE_RECV_STALLS,
      PACE_BOTH
   } pace_type;

   // Kinds of entries in the stimulus stream.
   typedef enum logic [1:0] {
      ENTRY_SAMPLE,
      ENTRY_RANK,
      ENTRY_PACE
   } entry_kind_type;

   typedef struct {
      entry_kind_type kind;
      data_type       value;
      kcfg_type       rank;
      pace_type       pace;
   } stream_entry_type;

   typedef struct {
      logic     ready_res;
      data_type kth_value;
   } kth_result_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     csr_wen;
   kcfg_type csr_wdata;
   pace_type pace = PACE_FULL;
   logic     pipe_empty = 1'b1;
   int       mismatch_count = 0;

   stream_entry_type stream_q[$];
   kth_result_type   kth_expected_q[$];

   // Shadow copy of the heap, the held count and the rank register.
   data_type heap_model [MAX_K];
   int       held_count;
   kcfg_type rank_reg;

   kth_req_if req_if();
   kth_rsp_if rsp_if();

   kth_largest_stream_tracker i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata)
   );

   // Clock with a period of 10.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // All block inputs start at known values before reset is released.
   initial begin
      req_if.valid  = 1'b0;
      req_if.sample = '0;
      rsp_if.ready  = 1'b0;
      csr_wen       = 1'b0;
      csr_wdata     = kcfg_type'(1);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // The rank in use: the register clamped to 1..MAX_K.
   function automatic int rank_limit();
      if (rank_reg == 0) return 1;
      if (rank_reg > MAX_K) return MAX_K;
      return int'(rank_reg);
   endfunction

   // Min-heap sift-down over the first size entries of the shadow heap.
   function automatic void sift_model(int pos, int size);
      int       lc;
      int       rc;
      int       best;
      data_type tmp;
      while (pos < size) begin
         lc   = 2 * pos + 1;
         rc   = lc + 1;
         best = pos;
         if (lc < size && heap_model[lc] < heap_model[best]) best = lc;
         if (rc < size && heap_model[rc] < heap_model[best]) best = rc;
         if (best == pos) break;
         tmp              = heap_model[pos];
         heap_model[pos]  = heap_model[best];
         heap_model[best] = tmp;
         pos              = best;
      end
   endfunction

   // Updates the shadow heap with one sample and returns the k-th largest value.
   function automatic kth_result_type track_sample(data_type x);
      int             k;
      int             idx;
      kth_result_type res;
      k = rank_limit();
      if (held_count < k) begin
         heap_model[held_count] = x;
         held_count++;
         if (held_count == k) begin
            for (idx = k / 2 - 1; idx >= 0; idx--) sift_model(idx, k);
         end
      end else if (x > heap_model[0]) begin
         heap_model[0] = x;
         sift_model(0, k);
      end
      res.ready_res = (held_count >= k);
      res.kth_value = res.ready_res ? heap_model[0] : data_type'(0);
      return res;
   endfunction

   function automatic bit sender_gap();
      case (pace)
         PACE_SEND_GAPS: return $urandom_range(0, 99) < 57;
         PACE_BOTH:      return $urandom_range(0, 99) < 18;
         default:        return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stall();
      case (pace)
         PACE_RECV_STALLS: return $urandom_range(0, 99) < 57;
         PACE_BOTH:        return $urandom_range(0, 99) < 18;
         default:          return 1'b0;
      endcase
   endfunction

   // A random sample: mostly full range, with clusters of small and extreme values.
   function automatic data_type pick_sample();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0:       return 32'sh7FFF_FFFF;
               1:       return 32'sh8000_0000;
               2:       return '0;
               default: return '1;
            endcase
         end
         1, 2:    return data_type'(int'($urandom_range(0, 16)) - 8);
         default: return data_type'($urandom());
      endcase
   endfunction

   task automatic push_sample(data_type value);
      stream_entry_type e;
      e.kind  = ENTRY_SAMPLE;
      e.value = value;
      e.rank  = '0;
      e.pace  = PACE_FULL;
      stream_q.push_back(e);
   endtask

   task automatic push_rank(int rank);
      stream_entry_type e;
      e.kind  = ENTRY_RANK;
      e.value = '0;
      e.rank  = kcfg_type'(rank);
      e.pace  = PACE_FULL;
      stream_q.push_back(e);
   endtask

   task automatic push_pace(pace_type p);
      stream_entry_type e;
      e.kind  = ENTRY_PACE;
      e.value = '0;
      e.rank  = '0;
      e.pace  = p;
      stream_q.push_back(e);
   endtask

   task automatic note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
   endtask

   // Driver: offers samples and rank writes from the stimulus stream.
   // A rank write waits until no transaction is outstanding.
   always @(posedge clock) begin : drive_proc
      logic             offer;
      logic             wen_next;
      stream_entry_type head;
      if (reset) begin
         req_if.valid <= 1'b0;
         csr_wen      <= 1'b0;
      end else begin
         offer    = req_if.valid && !req_if.ready;
         wen_next = 1'b0;
         if (!offer && stream_q.size() != 0) begin
            head = stream_q[0];
            case (head.kind)
               ENTRY_PACE: begin
                  pace <= head.pace;
                  void'(stream_q.pop_front());
               end
               ENTRY_RANK: begin
                  if (!req_if.valid && pipe_empty) begin
                     wen_next = 1'b1;
                     csr_wdata <= head.rank;
                     void'(stream_q.pop_front());
                  end
               end
               default: begin
                  if (!sender_gap()) begin
                     offer = 1'b1;
                     req_if.sample <= head.value;
                     void'(stream_q.pop_front());
                  end
               end
            endcase
         end
         req_if.valid <= offer;
         csr_wen      <= wen_next;
      end
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      rsp_if.ready <= !receiver_stall();
   end

   // Monitor: predicts each accepted sample and checks each accepted result.
   always @(posedge clock) begin : check_proc
      kth_result_type want;
      if (reset) begin
         rank_reg   = kcfg_type'(1);
         held_count = 0;
         foreach (heap_model[i]) heap_model[i] = '0;
         kth_expected_q.delete();
      end else begin
         if (csr_wen) begin
            rank_reg   = csr_wdata;
            held_count = 0;
         end
         if (req_if.valid && req_if.ready) begin
            kth_expected_q.push_back(track_sample(req_if.sample));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (kth_expected_q.size() == 0) begin
               note_mismatch($sformatf("unexpected result: ready_res=%0b kth_value=%0d",
                                       rsp_if.ready_res, rsp_if.kth_value));
            end else begin
               want = kth_expected_q.pop_front();
               if (rsp_if.ready_res !== want.ready_res ||
                   rsp_if.kth_value !== want.kth_value) begin
                  note_mismatch($sformatf(
                     "expected ready_res=%0b kth_value=%0d, got ready_res=%0b kth_value=%0d",
                     want.ready_res, want.kth_value, rsp_if.ready_res, rsp_if.kth_value));
               end
            end
         end
      end
      pipe_empty <= (kth_expected_q.size() == 0);
   end

   // Stimulus, then the wait for the last results and the verdict.
   initial begin : stim_proc
      int ranks [12];
      int seg;
      int count;
      int n;
      int eff;

      // Directed part: rank 1 from reset with extreme samples.
      push_pace(PACE_FULL);
      push_sample(32'sh7FFF_FFFF);
      push_sample(32'sh8000_0000);
      push_sample('0);
      push_sample('1);
      push_rank(1);
      push_sample(5);
      push_sample(4);
      // A rank of zero acts as one.
      push_rank(0);
      push_sample(-3);
      push_sample(9);
      // Equal to the minimum, below it and above it.
      push_rank(3);
      push_sample(3);
      push_sample(3);
      push_sample(3);
      push_sample(3);
      push_sample(1);
      push_sample(4);
      push_sample(32'sh8000_0000);
      // The rank is rewritten while the heap is only partly filled.
      push_rank(4);
      push_sample(10);
      push_sample(20);
      push_rank(2);
      push_sample(32'sh8000_0000);
      push_sample(32'sh8000_0000);
      push_sample(32'sh7FFF_FFFF);
      push_sample(32'sh7FFF_FFFF);
      push_sample(32'sh7FFF_FFFF);

      // Random part: phases with different ranks and pacing.
      ranks = '{64, 1, 127, 2, 0, 0, 0, 65, 64, 0, 3, 0};
      for (seg = 0; seg < 12; seg++) begin
         if (ranks[seg] == 0 && seg != 5) ranks[seg] = $urandom_range(1, 16);
         push_pace(pace_type'(seg % 4));
         push_rank(ranks[seg]);
         eff = (ranks[seg] < 1) ? 1 : (ranks[seg] > MAX_K) ? MAX_K : ranks[seg];
         // One phase stops before the heap is full.
         count = (seg == 8) ? $urandom_range(20, 50) : eff + $urandom_range(15, 55);
         for (n = 0; n < count; n++) push_sample(pick_sample());
      end
      push_rank(1);

      // Wait for every transaction to be accepted and every result to return.
      @(negedge clock);
      while (stream_q.size() != 0 || req_if.valid || !pipe_empty) @(negedge clock);
      repeat (40) @(negedge clock);

      if (mismatch_count == 0 && kth_expected_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #4000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

>>> filelist.f
src/kth_pkg.sv
src/kth_req_if.sv
src/kth_rsp_if.sv
src/kth_ram.sv
src/kth_ctrl.sv
src/kth_dp.sv
src/kth_largest_stream_tracker.sv
tb/kth_largest_stream_tracker_tb.sv
